FILE: rtl/core/rpv_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the rotate/project engine.
package rpv_pkg;

  // Field and register widths
  localparam int AngleW   = 32;
  localparam int StepW    = 24;
  localparam int ScaleW   = 15;
  localparam int VertW    = 17;
  localparam int TrigW    = 17;
  localparam int CoefW    = 17;
  localparam int ScreenW  = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // Stream word widths, padded to whole bytes
  localparam int SDataW = 56;
  localparam int MDataW = 32;

  // Shared multiply-accumulate unit
  localparam int MacAW = 35;
  localparam int MacBW = 17;
  localparam int AccW  = 50;

  // CORDIC
  localparam int TableLen       = 24;
  localparam int AtanW          = 30;
  localparam int AtanIdxW       = $clog2(TableLen);
  localparam int DefCordicSteps = 16;
  localparam int DefAngleBits   = 32;

  // Register reset values
  localparam logic [ScaleW-1:0] ScaleRst = 15'd32000;
  localparam logic [StepW-1:0]  StepYRst = 24'd2460835;
  localparam logic [StepW-1:0]  StepXRst = 24'd1517515;
  localparam logic [StepW-1:0]  StepZRst = 24'd936485;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegScale = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepX = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStepZ = 2'd3;

  // Input word kinds
  localparam logic OpTick   = 1'b0;
  localparam logic OpVertex = 1'b1;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_mode_e;

  typedef struct packed {
    mac_mode_e                mode;
    logic signed [MacAW-1:0]  a;
    logic signed [MacBW-1:0]  b;
  } mac_op_t;

  // atan(2^-i) in turns * 2^32
  function automatic logic [AtanW-1:0] atan_turn(input logic [AtanIdxW-1:0] idx);
    logic [AtanW-1:0] val;
    unique case (idx)
      5'd0:    val = 30'h20000000;
      5'd1:    val = 30'h12E4051E;
      5'd2:    val = 30'h09FB385B;
      5'd3:    val = 30'h051111D4;
      5'd4:    val = 30'h028B0D43;
      5'd5:    val = 30'h0145D7E1;
      5'd6:    val = 30'h00A2F61E;
      5'd7:    val = 30'h00517C55;
      5'd8:    val = 30'h0028BE53;
      5'd9:    val = 30'h00145F2F;
      5'd10:   val = 30'h000A2F98;
      5'd11:   val = 30'h000517CC;
      5'd12:   val = 30'h00028BE6;
      5'd13:   val = 30'h000145F3;
      5'd14:   val = 30'h0000A2FA;
      5'd15:   val = 30'h0000517D;
      5'd16:   val = 30'h000028BE;
      5'd17:   val = 30'h0000145F;
      5'd18:   val = 30'h00000A30;
      5'd19:   val = 30'h00000518;
      5'd20:   val = 30'h0000028C;
      5'd21:   val = 30'h00000146;
      5'd22:   val = 30'h000000A3;
      5'd23:   val = 30'h00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/rpv_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sine and cosine in Q1.15.
module rpv_cordic
  import rpv_pkg::*;
#(
  parameter int CORDIC_STEPS = DefCordicSteps,
  parameter int ANGLE_BITS   = DefAngleBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ANGLE_BITS-1:0]   angle_i,
  output logic                    done_o,
  output logic signed [TrigW-1:0] sin_o,
  output logic signed [TrigW-1:0] cos_o
);

  localparam int CordicIters = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam int IterW       = $clog2(CordicIters);
  localparam int XW          = 34;
  localparam int ZW          = 33;
  localparam int RW          = XW - 15;

  localparam logic signed [XW-1:0] Gain    = 34'sd652032874;
  localparam logic signed [ZW-1:0] Quarter = 33'sd1073741824;
  localparam logic signed [ZW-1:0] Half    = 33'sd2147483648;
  localparam logic [IterW-1:0]     LastIt  = IterW'(CordicIters - 1);

  typedef enum logic [1:0] {
    C_IDLE,
    C_ITER,
    C_ROUND
  } cstate_e;

  cstate_e                 state_q;
  logic signed [XW-1:0]    x_q, y_q;
  logic signed [ZW-1:0]    z_q;
  logic [IterW-1:0]        it_q;
  logic                    flip_q;
  logic                    done_q;
  logic signed [TrigW-1:0] sin_q, cos_q;

  logic [AngleW-1:0]       ang_full;
  logic signed [ZW-1:0]    z_init;
  logic signed [ZW-1:0]    z_fold;
  logic                    fold;
  logic signed [XW-1:0]    dx, dy;
  logic signed [ZW-1:0]    at;
  logic signed [XW-1:0]    x_bias, y_bias;
  logic signed [RW-1:0]    x_rnd, y_rnd;
  logic signed [TrigW-1:0] c_clamp, s_clamp;

  // Fold the angle into [-1/4, +1/4] turn
  always_comb begin
    ang_full = AngleW'(angle_i) << (AngleW - ANGLE_BITS);
    z_init   = {ang_full[AngleW-1], ang_full};
    fold     = 1'b0;
    z_fold   = z_init;
    if (z_init > Quarter) begin
      z_fold = z_init - Half;
      fold   = 1'b1;
    end else if (z_init < -Quarter) begin
      z_fold = z_init + Half;
      fold   = 1'b1;
    end
  end

  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = ZW'(atan_turn(AtanIdxW'(it_q)));

  // Round half up to Q1.15 and clamp to [-1, +1]
  always_comb begin
    x_bias = x_q + XW'(16384);
    y_bias = y_q + XW'(16384);
    x_rnd  = RW'(x_bias >>> 15);
    y_rnd  = RW'(y_bias >>> 15);
    if (x_rnd > RW'(32768))       c_clamp = 17'sd32768;
    else if (x_rnd < -RW'(32768)) c_clamp = -17'sd32768;
    else                          c_clamp = x_rnd[TrigW-1:0];
    if (y_rnd > RW'(32768))       s_clamp = 17'sd32768;
    else if (y_rnd < -RW'(32768)) s_clamp = -17'sd32768;
    else                          s_clamp = y_rnd[TrigW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      it_q    <= '0;
      flip_q  <= 1'b0;
      done_q  <= 1'b0;
      sin_q   <= '0;
      cos_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            x_q     <= Gain;
            y_q     <= '0;
            z_q     <= z_fold;
            flip_q  <= fold;
            it_q    <= '0;
            state_q <= C_ITER;
          end
        end
        C_ITER: begin
          if (!z_q[ZW-1]) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + at;
          end
          if (it_q == LastIt) state_q <= C_ROUND;
          else                it_q    <= it_q + 1'b1;
        end
        C_ROUND: begin
          cos_q   <= flip_q ? -c_clamp : c_clamp;
          sin_q   <= flip_q ? -s_clamp : s_clamp;
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

FILE: rtl/core/rpv_mac.sv
// Shared multiply-accumulate unit: registered product, then load, add or subtract into the accumulator.
module rpv_mac
  import rpv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   op_valid_i,
  input  mac_op_t                op_i,
  output logic                   done_o,
  output logic signed [AccW-1:0] acc_o
);

  logic signed [MacAW+MacBW-1:0] prod_full;
  logic signed [AccW-1:0]        prod_q;
  logic signed [AccW-1:0]        acc_q;
  mac_mode_e                     mode_q;
  logic                          v1_q;
  logic                          done_q;

  assign prod_full = op_i.a * op_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
      mode_q <= MAC_LOAD;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      v1_q   <= op_valid_i;
      done_q <= v1_q;
      if (op_valid_i) begin
        // operand ranges keep every product inside the accumulator width
        prod_q <= prod_full[AccW-1:0];
        mode_q <= op_i.mode;
      end
      if (v1_q) begin
        unique case (mode_q)
          MAC_LOAD: acc_q <= prod_q;
          MAC_ADD:  acc_q <= acc_q + prod_q;
          MAC_SUB:  acc_q <= acc_q - prod_q;
          default:  acc_q <= prod_q;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

FILE: rtl/core/rotate_project_vertex.sv
// Top level of the rotate/project engine: sequencer, state, stream and register ports.
//
// Vector-display geometry engine. A frame-tick word (tuser = 0) advances the Y, X and Z angle
// accumulators (32-bit turns) by step_y/step_x/step_z, takes sine and cosine of each new angle
// with an iterative CORDIC, and rebuilds the first two rows of Ry*Rx*Rz in Q1.15; it produces
// no output word. A vertex word (tuser = 1) carries a Q3.14 point; its output word holds the
// dot products with both rows, times the scale register, divided by 2^29 with truncation toward
// zero, saturated to 16 bits, and a clipped flag in tuser. The block takes one input word at a
// time and drops tready until it is done. A vertex runs eight multiply-accumulate operations
// through the single 35x17 multiplier, then the output state, then returns to idle, where the
// next word is taken; the output state waits while the last output word is still held. A frame
// tick runs the CORDIC for each of the three angles in turn, one micro-rotation per cycle, then
// the same multiplier forms the eight matrix products. A finished output word waits in its own
// register, so a stalled consumer only blocks the next vertex at its output state. Register
// writes take effect at once and are meant for idle periods.
module rotate_project_vertex
  import rpv_pkg::*;
#(
  parameter int CORDIC_STEPS = DefCordicSteps,
  parameter int ANGLE_BITS   = DefAngleBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SDataW-1:0]   s_axis_tdata,  // vert_x[16:0], vert_y[33:17], vert_z[50:34], zero
  input  logic                s_axis_tuser,  // opcode
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [MDataW-1:0]   m_axis_tdata,  // screen_x[15:0], screen_y[31:16]
  output logic                m_axis_tuser,  // clipped
  // register write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORD_GO,
    S_CORD_WAIT,
    S_MAT_OP,
    S_MAT_WAIT,
    S_VTX_OP,
    S_VTX_WAIT,
    S_OUT
  } state_e;

  // angle being run through the CORDIC
  localparam logic [1:0] TrigY = 2'd0;
  localparam logic [1:0] TrigX = 2'd1;
  localparam logic [1:0] TrigZ = 2'd2;

  // matrix build sequence
  localparam logic [2:0] MatP      = 3'd0;  // p = sy*sx
  localparam logic [2:0] MatCyCz   = 3'd1;
  localparam logic [2:0] MatM00    = 3'd2;  // + p*sz
  localparam logic [2:0] MatPCz    = 3'd3;
  localparam logic [2:0] MatM01    = 3'd4;  // - cy*sz
  localparam logic [2:0] MatM02    = 3'd5;
  localparam logic [2:0] MatM10    = 3'd6;
  localparam logic [2:0] MatM11    = 3'd7;

  // per-row vertex sequence
  localparam logic [2:0] VtxX      = 3'd0;
  localparam logic [2:0] VtxY      = 3'd1;
  localparam logic [2:0] VtxZ      = 3'd2;
  localparam logic [2:0] VtxScale  = 3'd3;

  state_e                   state_q;
  logic [2:0]               step_q;
  logic [1:0]               tidx_q;
  logic                     row_sel_q;

  logic [ScaleW-1:0]        scale_q;
  logic [StepW-1:0]         step_y_q, step_x_q, step_z_q;
  logic [AngleW-1:0]        angle_y_q, angle_x_q, angle_z_q;

  logic signed [TrigW-1:0]  sy_q, cy_q, sx_q, cx_q, sz_q, cz_q;
  logic signed [TrigW-1:0]  p_q;
  logic signed [CoefW-1:0]  row0_q [3];
  logic signed [CoefW-1:0]  row1_q [3];

  logic signed [VertW-1:0]  vx_q, vy_q, vz_q;
  logic signed [ScreenW-1:0] scr_x_q;
  logic                     clip_x_q;
  logic signed [ScreenW-1:0] scr_y_q;
  logic                     clip_y_q;

  logic                     m_valid_q;
  logic [MDataW-1:0]        m_data_q;
  logic                     m_user_q;

  logic                     s_fire;
  logic [AngleW-1:0]        cord_angle;
  logic                     cord_done;
  logic signed [TrigW-1:0]  cord_sin, cord_cos;

  logic                     mac_valid;
  mac_op_t                  mac_op;
  logic                     mac_done;
  logic signed [AccW-1:0]   mac_acc;

  logic signed [AccW-1:0]   acc_bias, acc_rnd;
  logic signed [CoefW-1:0]  coef_val;
  logic signed [AccW-1:0]   trunc_bias, trunc_val;
  logic signed [ScreenW-1:0] sat_val;
  logic                     sat_clip;
  logic signed [CoefW-1:0]  row_c;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // CORDIC for the three angles, one after the other
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (tidx_q)
      TrigY:   cord_angle = angle_y_q;
      TrigX:   cord_angle = angle_x_q;
      default: cord_angle = angle_z_q;
    endcase
  end

  rpv_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_CORD_GO),
    .angle_i (cord_angle[AngleW-1 -: ANGLE_BITS]),
    .done_o  (cord_done),
    .sin_o   (cord_sin),
    .cos_o   (cord_cos)
  );

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    row_c = row_sel_q ? row1_q[0] : row0_q[0];
    if (step_q == VtxY) row_c = row_sel_q ? row1_q[1] : row0_q[1];
    if (step_q == VtxZ) row_c = row_sel_q ? row1_q[2] : row0_q[2];
  end

  always_comb begin
    mac_valid   = (state_q == S_MAT_OP) || (state_q == S_VTX_OP);
    mac_op.mode = MAC_LOAD;
    mac_op.a    = '0;
    mac_op.b    = '0;
    if (state_q == S_VTX_OP) begin
      unique case (step_q)
        VtxX: begin
          mac_op.a = MacAW'(row_c);
          mac_op.b = MacBW'(vx_q);
        end
        VtxY: begin
          mac_op.mode = MAC_ADD;
          mac_op.a    = MacAW'(row_c);
          mac_op.b    = MacBW'(vy_q);
        end
        VtxZ: begin
          mac_op.mode = MAC_ADD;
          mac_op.a    = MacAW'(row_c);
          mac_op.b    = MacBW'(vz_q);
        end
        VtxScale: begin
          // dot product is bounded by 3*2^32, so its low bits carry it whole
          mac_op.a = mac_acc[MacAW-1:0];
          mac_op.b = MacBW'(scale_q);
        end
        default: mac_op.mode = MAC_LOAD;
      endcase
    end else begin
      unique case (step_q)
        MatP: begin
          mac_op.a = MacAW'(sy_q);
          mac_op.b = sx_q;
        end
        MatCyCz: begin
          mac_op.a = MacAW'(cy_q);
          mac_op.b = cz_q;
        end
        MatM00: begin
          mac_op.mode = MAC_ADD;
          mac_op.a    = MacAW'(p_q);
          mac_op.b    = sz_q;
        end
        MatPCz: begin
          mac_op.a = MacAW'(p_q);
          mac_op.b = cz_q;
        end
        MatM01: begin
          mac_op.mode = MAC_SUB;
          mac_op.a    = MacAW'(cy_q);
          mac_op.b    = sz_q;
        end
        MatM02: begin
          mac_op.a = MacAW'(sy_q);
          mac_op.b = cx_q;
        end
        MatM10: begin
          mac_op.a = MacAW'(cx_q);
          mac_op.b = sz_q;
        end
        MatM11: begin
          mac_op.a = MacAW'(cx_q);
          mac_op.b = cz_q;
        end
        default: mac_op.mode = MAC_LOAD;
      endcase
    end
  end

  rpv_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (mac_valid),
    .op_i       (mac_op),
    .done_o     (mac_done),
    .acc_o      (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Result shaping
  // ---------------------------------------------------------------------------
  // Q2.30 sum back to Q1.15, round half up; coefficients clamp to 17-bit signed
  always_comb begin
    acc_bias = mac_acc + AccW'(16384);
    acc_rnd  = acc_bias >>> 15;
    if (acc_rnd > AccW'(65535))       coef_val = 17'sd65535;
    else if (acc_rnd < -AccW'(65536)) coef_val = 17'sh10000;
    else                              coef_val = acc_rnd[CoefW-1:0];
  end

  // divide by 2^29 toward zero, then saturate to 16 bits
  always_comb begin
    trunc_bias = mac_acc[AccW-1] ? AccW'(29'h1FFFFFFF) : '0;
    trunc_val  = (mac_acc + trunc_bias) >>> 29;
    sat_clip   = 1'b0;
    if (trunc_val > AccW'(32767)) begin
      sat_val  = 16'sh7FFF;
      sat_clip = 1'b1;
    end else if (trunc_val < -AccW'(32768)) begin
      sat_val  = -16'sh8000;
      sat_clip = 1'b1;
    end else begin
      sat_val  = trunc_val[ScreenW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, state and registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      tidx_q    <= TrigY;
      row_sel_q <= 1'b0;
      scale_q   <= ScaleRst;
      step_y_q  <= StepYRst;
      step_x_q  <= StepXRst;
      step_z_q  <= StepZRst;
      angle_y_q <= '0;
      angle_x_q <= '0;
      angle_z_q <= '0;
      sy_q      <= '0;
      cy_q      <= '0;
      sx_q      <= '0;
      cx_q      <= '0;
      sz_q      <= '0;
      cz_q      <= '0;
      p_q       <= '0;
      row0_q[0] <= 17'sd32768;
      row0_q[1] <= '0;
      row0_q[2] <= '0;
      row1_q[0] <= '0;
      row1_q[1] <= 17'sd32768;
      row1_q[2] <= '0;
      vx_q      <= '0;
      vy_q      <= '0;
      vz_q      <= '0;
      scr_x_q   <= '0;
      clip_x_q  <= 1'b0;
      scr_y_q   <= '0;
      clip_y_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegScale: scale_q  <= cfg_data_i[ScaleW-1:0];
          RegStepY: step_y_q <= cfg_data_i[StepW-1:0];
          RegStepX: step_x_q <= cfg_data_i[StepW-1:0];
          RegStepZ: step_z_q <= cfg_data_i[StepW-1:0];
          default:  scale_q  <= scale_q;
        endcase
      end

      // drop the output word once taken, unless a new one loads in the same cycle
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) m_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser == OpTick) begin
              // accumulators wrap modulo one turn
              angle_y_q <= angle_y_q + AngleW'(step_y_q);
              angle_x_q <= angle_x_q + AngleW'(step_x_q);
              angle_z_q <= angle_z_q + AngleW'(step_z_q);
              tidx_q    <= TrigY;
              state_q   <= S_CORD_GO;
            end else begin
              vx_q      <= s_axis_tdata[VertW-1:0];
              vy_q      <= s_axis_tdata[2*VertW-1:VertW];
              vz_q      <= s_axis_tdata[3*VertW-1:2*VertW];
              step_q    <= VtxX;
              row_sel_q <= 1'b0;
              state_q   <= S_VTX_OP;
            end
          end
        end

        S_CORD_GO: state_q <= S_CORD_WAIT;

        S_CORD_WAIT: begin
          if (cord_done) begin
            unique case (tidx_q)
              TrigY: begin
                sy_q <= cord_sin;
                cy_q <= cord_cos;
              end
              TrigX: begin
                sx_q <= cord_sin;
                cx_q <= cord_cos;
              end
              default: begin
                sz_q <= cord_sin;
                cz_q <= cord_cos;
              end
            endcase
            if (tidx_q == TrigZ) begin
              step_q  <= MatP;
              state_q <= S_MAT_OP;
            end else begin
              tidx_q  <= tidx_q + 1'b1;
              state_q <= S_CORD_GO;
            end
          end
        end

        S_MAT_OP: state_q <= S_MAT_WAIT;

        S_MAT_WAIT: begin
          if (mac_done) begin
            unique case (step_q)
              MatP:    p_q       <= acc_rnd[TrigW-1:0];
              MatM00:  row0_q[0] <= coef_val;
              MatM01:  row0_q[1] <= coef_val;
              MatM02:  row0_q[2] <= coef_val;
              MatM10:  row1_q[0] <= coef_val;
              MatM11: begin
                row1_q[1] <= coef_val;
                // -sx stays within 17 bits for any sine in [-1, +1]
                row1_q[2] <= -sx_q;
              end
              default: p_q <= p_q;
            endcase
            if (step_q == MatM11) begin
              state_q <= S_IDLE;
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= S_MAT_OP;
            end
          end
        end

        S_VTX_OP: state_q <= S_VTX_WAIT;

        S_VTX_WAIT: begin
          if (mac_done) begin
            if (step_q == VtxScale) begin
              if (!row_sel_q) begin
                scr_x_q   <= sat_val;
                clip_x_q  <= sat_clip;
                row_sel_q <= 1'b1;
                step_q    <= VtxX;
                state_q   <= S_VTX_OP;
              end else begin
                // hold screen_y until the output slot frees
                scr_y_q  <= sat_val;
                clip_y_q <= sat_clip;
                state_q  <= S_OUT;
              end
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= S_VTX_OP;
            end
          end
        end

        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {scr_y_q, scr_x_q};
            m_user_q  <= clip_x_q | clip_y_q;
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: rtl/core/rpv_checker.sv
// Port-level assertions for the rotate/project engine and their bind to the top level.
module rpv_checker
  import rpv_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [MDataW-1:0]   m_axis_tdata,
  input logic                m_axis_tuser
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("ready stayed high after an accepted word");

  // a frame tick accepted while no output word is pending leaves the output valid low
  a_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == OpTick) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output word after a frame tick");

  // clipped means at least one coordinate sits on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[15:0] == 16'h7FFF) || (m_axis_tdata[15:0] == 16'h8000) ||
      (m_axis_tdata[31:16] == 16'h7FFF) || (m_axis_tdata[31:16] == 16'h8000))
    else $error("clipped flag without a saturated coordinate");

endmodule

bind rotate_project_vertex rpv_checker u_rpv_checker (.*);
